>>> rtl/ksc_pkg.sv
`default_nettype none

package ksc_pkg;

  localparam int NAME_COUNT   = 30;
  localparam int MAX_NAME_LEN = 9;
  localparam int NAME_LEN_W   = $clog2(MAX_NAME_LEN + 1);
  localparam int NAME_BITS    = 8 * MAX_NAME_LEN;
  localparam int NAME_IDX_W   = $clog2(NAME_COUNT);
  localparam int UNIT_W       = 16;
  localparam int POS_W        = 16;

  localparam logic [POS_W-1:0] POSITION_LIMIT = POS_W'(65535);

  localparam logic [UNIT_W-1:0] UNIT_LT    = 16'h003C;
  localparam logic [UNIT_W-1:0] UNIT_GT    = 16'h003E;
  localparam logic [UNIT_W-1:0] UNIT_CR    = 16'h000D;
  localparam logic [UNIT_W-1:0] UNIT_LF    = 16'h000A;
  localparam logic [UNIT_W-1:0] ASCII_MAX  = 16'h007F;
  localparam logic [UNIT_W-1:0] UPPER_A    = 16'h0041;
  localparam logic [UNIT_W-1:0] UPPER_Z    = 16'h005A;
  localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              final_unit;
  } item_t;

  typedef struct packed {
    logic              valid_res;
    logic [POS_W-1:0]  error_offset;
  } result_t;

  typedef struct packed {
    logic [NAME_BITS-1:0]  chars;  // first character in the top byte, zero padded
    logic [NAME_LEN_W-1:0] len;
  } key_name_t;

  function automatic key_name_t key_name(input logic [NAME_IDX_W-1:0] k);
    key_name_t             r;
    logic [NAME_BITS-1:0]  s;
    logic [NAME_LEN_W-1:0] n;
    s = '0;
    n = '0;
    unique case (k)
      5'd0:  begin s = NAME_BITS'("delay");     n = 4'd5; end
      5'd1:  begin s = NAME_BITS'("enter");     n = 4'd5; end
      5'd2:  begin s = NAME_BITS'("return");    n = 4'd6; end
      5'd3:  begin s = NAME_BITS'("tab");       n = 4'd3; end
      5'd4:  begin s = NAME_BITS'("esc");       n = 4'd3; end
      5'd5:  begin s = NAME_BITS'("escape");    n = 4'd6; end
      5'd6:  begin s = NAME_BITS'("backspace"); n = 4'd9; end
      5'd7:  begin s = NAME_BITS'("space");     n = 4'd5; end
      5'd8:  begin s = NAME_BITS'("delete");    n = 4'd6; end
      5'd9:  begin s = NAME_BITS'("insert");    n = 4'd6; end
      5'd10: begin s = NAME_BITS'("home");      n = 4'd4; end
      5'd11: begin s = NAME_BITS'("end");       n = 4'd3; end
      5'd12: begin s = NAME_BITS'("pageup");    n = 4'd6; end
      5'd13: begin s = NAME_BITS'("pagedown");  n = 4'd8; end
      5'd14: begin s = NAME_BITS'("up");        n = 4'd2; end
      5'd15: begin s = NAME_BITS'("down");      n = 4'd4; end
      5'd16: begin s = NAME_BITS'("left");      n = 4'd4; end
      5'd17: begin s = NAME_BITS'("right");     n = 4'd5; end
      5'd18: begin s = NAME_BITS'("f1");        n = 4'd2; end
      5'd19: begin s = NAME_BITS'("f2");        n = 4'd2; end
      5'd20: begin s = NAME_BITS'("f3");        n = 4'd2; end
      5'd21: begin s = NAME_BITS'("f4");        n = 4'd2; end
      5'd22: begin s = NAME_BITS'("f5");        n = 4'd2; end
      5'd23: begin s = NAME_BITS'("f6");        n = 4'd2; end
      5'd24: begin s = NAME_BITS'("f7");        n = 4'd2; end
      5'd25: begin s = NAME_BITS'("f8");        n = 4'd2; end
      5'd26: begin s = NAME_BITS'("f9");        n = 4'd2; end
      5'd27: begin s = NAME_BITS'("f10");       n = 4'd3; end
      5'd28: begin s = NAME_BITS'("f11");       n = 4'd3; end
      5'd29: begin s = NAME_BITS'("f12");       n = 4'd3; end
      default: begin s = '0; n = '1; end
    endcase
    // literals come right-justified; move the first character to the top byte
    r.chars = s << (8 * (MAX_NAME_LEN - int'(n)));
    r.len   = n;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ksc_in_reg.sv
`default_nettype none

module ksc_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire ksc_pkg::item_t item,
  output logic                held_valid,
  input  wire logic           held_take,
  output ksc_pkg::item_t      held
);

  assign item_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ksc_parser.sv
`default_nettype none

module ksc_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire ksc_pkg::item_t item,
  output logic                res_load,
  output ksc_pkg::result_t    res
);

  typedef enum logic [4:0] {
    MODE_START      = 5'b00001,
    MODE_AFTER_LT   = 5'b00010,
    MODE_IN_NAME    = 5'b00100,
    MODE_AFTER_CR   = 5'b01000,
    MODE_AFTER_HIGH = 5'b10000
  } mode_t;

  mode_t                              mode, mode_next;
  logic [ksc_pkg::POS_W-1:0]          position, position_next;
  logic [ksc_pkg::POS_W-1:0]          token_start, token_start_next;
  logic [ksc_pkg::NAME_LEN_W-1:0]     name_length, name_length_next;
  logic [ksc_pkg::NAME_COUNT-1:0]     cand, cand_next;
  logic                               failed, failed_next;

  logic [ksc_pkg::UNIT_W-1:0]         u;
  logic                               is_high, is_low;
  logic [ksc_pkg::NAME_LEN_W-1:0]     len_sel;
  logic [ksc_pkg::NAME_COUNT-1:0]     cand_sel, len_hit, char_hit;
  logic [7:0]                         lower;
  logic                               end_fail;

  assign u       = item.code_unit;
  assign is_high = (u >= ksc_pkg::HIGH_FIRST) && (u <= ksc_pkg::HIGH_LAST);
  assign is_low  = (u >= ksc_pkg::LOW_FIRST) && (u <= ksc_pkg::LOW_LAST);

  // a fresh name starts right after '<' with every key still a candidate
  assign len_sel  = (mode == MODE_AFTER_LT) ? '0 : name_length;
  assign cand_sel = (mode == MODE_AFTER_LT) ? '1 : cand;

  always_comb begin
    if ((u >= ksc_pkg::UPPER_A) && (u <= ksc_pkg::UPPER_Z)) begin
      lower = u[7:0] + 8'h20;
    end else begin
      lower = u[7:0];
    end
  end

  always_comb begin
    ksc_pkg::key_name_t kn;
    for (int k = 0; k < ksc_pkg::NAME_COUNT; k++) begin
      kn          = ksc_pkg::key_name(ksc_pkg::NAME_IDX_W'(k));
      len_hit[k]  = (kn.len == len_sel);
      char_hit[k] = 1'b0;
      if (len_sel < ksc_pkg::NAME_LEN_W'(ksc_pkg::MAX_NAME_LEN)) begin
        char_hit[k] = (kn.chars[ksc_pkg::NAME_BITS - 1 - 8 * int'(len_sel) -: 8] == lower);
      end
    end
  end

  always_comb begin
    mode_next        = mode;
    position_next    = position;
    token_start_next = token_start;
    name_length_next = name_length;
    cand_next        = cand;
    failed_next      = failed;

    if (!failed) begin
      priority if ((mode == MODE_AFTER_LT) && (u == ksc_pkg::UNIT_LT)) begin
        mode_next = MODE_START;
      end else if ((mode == MODE_AFTER_LT) || (mode == MODE_IN_NAME)) begin
        if (u == ksc_pkg::UNIT_GT) begin
          if (|(cand_sel & len_hit)) mode_next = MODE_START;
          else failed_next = 1'b1;
        end else if ((u > ksc_pkg::ASCII_MAX) ||
                     (len_sel >= ksc_pkg::NAME_LEN_W'(ksc_pkg::MAX_NAME_LEN))) begin
          failed_next = 1'b1;
        end else begin
          cand_next        = cand_sel & char_hit;
          name_length_next = len_sel + 1'b1;
          mode_next        = MODE_IN_NAME;
        end
      end else if ((mode == MODE_AFTER_HIGH)) begin
        if (is_low) mode_next = MODE_START;
        else failed_next = 1'b1;
      end else if ((mode == MODE_AFTER_CR) && (u == ksc_pkg::UNIT_LF)) begin
        mode_next = MODE_START;
      end else begin
        // new token
        token_start_next = position;
        priority if (u == ksc_pkg::UNIT_LT) mode_next = MODE_AFTER_LT;
        else if (u == ksc_pkg::UNIT_CR) mode_next = MODE_AFTER_CR;
        else if (is_high) mode_next = MODE_AFTER_HIGH;
        else if (is_low) failed_next = 1'b1;
        else mode_next = MODE_START;
      end
      if (position != ksc_pkg::POSITION_LIMIT) begin
        position_next = position + 1'b1;
      end
    end
  end

  assign end_fail = failed_next || (mode_next == MODE_AFTER_LT) ||
                    (mode_next == MODE_IN_NAME) || (mode_next == MODE_AFTER_HIGH);

  assign res_load           = step && item.final_unit;
  assign res.valid_res      = !end_fail;
  assign res.error_offset   = end_fail ? token_start_next : '0;

  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      mode        <= MODE_START;
      position    <= '0;
      token_start <= '0;
      name_length <= '0;
      failed      <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      position    <= position_next;
      token_start <= token_start_next;
      name_length <= name_length_next;
      failed      <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cand <= cand_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ksc_out_reg.sv
`default_nettype none

module ksc_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_load,
  input  wire ksc_pkg::result_t res,
  output logic                  res_room,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output ksc_pkg::result_t      result
);

  assign res_room = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/key_sequence_syntax_checker.sv
// Path: a final code unit is held in the input register after its transfer, then parsed
// into the result register once that register has room.
// Throughput: one code unit per cycle unless a final unit stalls; the single-step parse state update sets this.
// A final unit waits in the input register only while the result register is full.
// Reset (rst, synchronous): parser returns to token start, position 0, no result pending.
`default_nettype none

module key_sequence_syntax_checker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ksc_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output ksc_pkg::result_t      result
);

  logic             held_valid, step, res_load, res_room;
  ksc_pkg::item_t   held;
  ksc_pkg::result_t res;

  // non-final units never need the result register
  assign step = held_valid && (!held.final_unit || res_room);

  ksc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .held_valid (held_valid),
    .held_take  (step),
    .held       (held)
  );

  ksc_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (held),
    .res_load (res_load),
    .res      (res)
  );

  ksc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .res_room     (res_room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [2:0] {
    AT_TOKEN,
    AFTER_LT,
    IN_NAME,
    AFTER_CR,
    AFTER_HIGH
  } scan_mode_t;

  // Directed string: one char per code unit, with stand-ins for units a
  // string literal cannot hold (see the decode in the stimulus loop).
  typedef struct {
    string       text;
    bit          typed;
    bit          ok;
    logic [15:0] offset;
  } dir_row_t;

  typedef struct packed {
    bit               typed;
    ksc_pkg::result_t res;
  } verdict_src_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  ksc_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  ksc_pkg::result_t result;

  key_sequence_syntax_checker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  string key_names [ksc_pkg::NAME_COUNT] = '{
    "delay", "enter", "return", "tab", "esc", "escape", "backspace", "space",
    "delete", "insert", "home", "end", "pageup", "pagedown", "up", "down",
    "left", "right", "f1", "f2", "f3", "f4", "f5", "f6", "f7", "f8", "f9",
    "f10", "f11", "f12"
  };

  // # D800, $ DBFF, % DC00, & DFFF, ~ FFFF, @ 0000, | 0080, ^ CR, _ LF
  dir_row_t dir_rows [25] = '{
    '{"<enter>",                     1'b1, 1'b1, 16'd0},
    '{"<>",                          1'b1, 1'b0, 16'd0},
    '{"<",                           1'b1, 1'b0, 16'd0},
    '{"a<<b<<",                      1'b1, 1'b1, 16'd0},
    '{"<DeLaY><F12><f1><BackSpace>", 1'b1, 1'b1, 16'd0},
    '{"x<abc>",                      1'b1, 1'b0, 16'd1},
    '{"ab<enter",                    1'b1, 1'b0, 16'd2},
    '{"^_^z^",                       1'b1, 1'b1, 16'd0},
    '{"#%$&",                        1'b1, 1'b1, 16'd0},
    '{"a#b",                         1'b1, 1'b0, 16'd1},
    '{"a#",                          1'b1, 1'b0, 16'd1},
    '{"ab%",                         1'b1, 1'b0, 16'd2},
    '{"^%",                          1'b1, 1'b0, 16'd1},
    '{"@a<@>",                       1'b1, 1'b0, 16'd2},
    '{"<backspacex>",                1'b1, 1'b0, 16'd0},
    '{"z<esc|>",                     1'b1, 1'b0, 16'd1},
    '{"~|@",                         1'b1, 1'b1, 16'd0},
    '{"<<<tab>",                     1'b1, 1'b1, 16'd0},
    '{"a<b>c<up>",                   1'b1, 1'b0, 16'd1},
    '{"<up>^#",                      1'b1, 1'b0, 16'd5},
    '{"<a<>",                        1'b1, 1'b0, 16'd0},
    '{"#^",                          1'b1, 1'b0, 16'd0},
    '{"<PageDown><pageup><HOME><End><insert><delete><space>", 1'b0, 1'b0, 16'd0},
    '{"<left><right><down><return><esc><ESCAPE><Tab><enter><delay>",
      1'b0, 1'b0, 16'd0},
    '{"<f2><F3><f4><F5><f6><F7><f8><F9><f10><F11><f12><F1>", 1'b0, 1'b0, 16'd0}
  };

  ksc_pkg::item_t   unit_feed [$];
  verdict_src_t     row_verdicts [$];
  ksc_pkg::result_t verdicts_due [$];
  int               fault_count = 0;

  bit hold_go = 1'b0;

  // ---- predictor state ----
  scan_mode_t  scan_mode = AT_TOKEN;
  logic [15:0] unit_pos = '0;
  logic [15:0] tok_pos = '0;
  logic [7:0]  name_buf [ksc_pkg::MAX_NAME_LEN];
  int          name_len = 0;
  bit          scan_failed = 1'b0;

  function automatic bit name_known();
    string s;
    bit    hit;
    for (int k = 0; k < ksc_pkg::NAME_COUNT; k++) begin
      s = key_names[k];
      if (s.len() == name_len) begin
        hit = 1'b1;
        for (int i = 0; i < name_len; i++)
          if (s[i] != name_buf[i]) hit = 1'b0;
        if (hit) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void begin_token(logic [15:0] u);
    tok_pos = unit_pos;
    if (u == ksc_pkg::UNIT_LT) scan_mode = AFTER_LT;
    else if (u == ksc_pkg::UNIT_CR) scan_mode = AFTER_CR;
    else if (u >= ksc_pkg::HIGH_FIRST && u <= ksc_pkg::HIGH_LAST) scan_mode = AFTER_HIGH;
    else if (u >= ksc_pkg::LOW_FIRST && u <= ksc_pkg::LOW_LAST) scan_failed = 1'b1;
    else scan_mode = AT_TOKEN;
  endfunction

  function automatic void take_name_char(logic [15:0] u);
    logic [15:0] c;
    c = u;
    if (u == ksc_pkg::UNIT_GT) begin
      if (name_known()) scan_mode = AT_TOKEN;
      else scan_failed = 1'b1;
    end else if (u > ksc_pkg::ASCII_MAX || name_len >= ksc_pkg::MAX_NAME_LEN) begin
      // can never match: the token fails at its '<'
      scan_failed = 1'b1;
    end else begin
      if (u >= ksc_pkg::UPPER_A && u <= ksc_pkg::UPPER_Z) c = u + 16'h0020;
      name_buf[name_len] = c[7:0];
      name_len++;
      scan_mode = IN_NAME;
    end
  endfunction

  function automatic bit scan_unit(input ksc_pkg::item_t it, output ksc_pkg::result_t res);
    logic [15:0] u;
    u = it.code_unit;
    res = '0;
    if (!scan_failed) begin
      case (scan_mode)
        AFTER_LT: begin
          if (u == ksc_pkg::UNIT_LT) begin
            scan_mode = AT_TOKEN;
          end else begin
            name_len = 0;
            take_name_char(u);
          end
        end
        IN_NAME: take_name_char(u);
        AFTER_CR: begin
          if (u == ksc_pkg::UNIT_LF) scan_mode = AT_TOKEN;
          else begin_token(u);
        end
        AFTER_HIGH: begin
          if (u >= ksc_pkg::LOW_FIRST && u <= ksc_pkg::LOW_LAST) scan_mode = AT_TOKEN;
          else scan_failed = 1'b1;
        end
        default: begin_token(u);
      endcase
      if (unit_pos < ksc_pkg::POSITION_LIMIT) unit_pos++;
    end
    if (!it.final_unit) return 1'b0;
    if (scan_mode == AFTER_LT || scan_mode == IN_NAME || scan_mode == AFTER_HIGH)
      scan_failed = 1'b1;
    res.valid_res    = !scan_failed;
    res.error_offset = scan_failed ? tok_pos : '0;
    scan_mode   = AT_TOKEN;
    unit_pos    = '0;
    tok_pos     = '0;
    name_len    = 0;
    scan_failed = 1'b0;
    return 1'b1;
  endfunction

  // ---- stimulus helpers ----
  task automatic queue_string(logic [15:0] units [$], bit typed, ksc_pkg::result_t res);
    ksc_pkg::item_t it;
    verdict_src_t   v;
    foreach (units[i]) begin
      it.code_unit  = units[i];
      it.final_unit = (i == units.size() - 1);
      unit_feed.push_back(it);
    end
    v.typed = typed;
    v.res   = res;
    row_verdicts.push_back(v);
  endtask

  function automatic logic [15:0] letter_unit(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) c = c - 8'h20;
    return {8'h00, c};
  endfunction

  function automatic logic [15:0] text_unit();
    logic [15:0] u;
    case ($urandom_range(0, 2))
      0: u = 16'($urandom_range(16'h0020, 16'h007E));
      1: u = 16'($urandom_range(16'h0000, 16'hD7FF));
      default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
    if (u == ksc_pkg::UNIT_LT || u == ksc_pkg::UNIT_CR) u = 16'h0078;
    return u;
  endfunction

  function automatic logic [15:0] noise_unit();
    case ($urandom_range(0, 6))
      0: return 16'($urandom);
      1: return ksc_pkg::UNIT_LT;
      2: return ksc_pkg::UNIT_GT;
      3: return $urandom_range(0, 1) ? ksc_pkg::UNIT_CR : ksc_pkg::UNIT_LF;
      4: return 16'($urandom_range(ksc_pkg::HIGH_FIRST, ksc_pkg::LOW_LAST));
      5: return 16'h0000;
      default: return letter_unit(8'($urandom_range(8'h61, 8'h7A)));
    endcase
  endfunction

  // Mostly well-formed token runs, some with one broken token, some raw noise.
  task automatic make_random_string(ref logic [15:0] units [$]);
    int    n_tokens;
    int    fault_at;
    string nm;
    units.delete();
    if ($urandom_range(0, 3) == 0) begin
      n_tokens = $urandom_range(1, 8);
      repeat (n_tokens) units.push_back(noise_unit());
      return;
    end
    n_tokens = $urandom_range(1, 6);
    fault_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_tokens - 1) : -1;
    for (int t = 0; t < n_tokens; t++) begin
      if (t == fault_at) begin
        case ($urandom_range(0, 6))
          0: begin
            units.push_back(ksc_pkg::UNIT_LT);
            repeat ($urandom_range(1, 6))
              units.push_back(letter_unit(8'($urandom_range(8'h61, 8'h7A))));
            units.push_back(ksc_pkg::UNIT_GT);
          end
          1: begin
            units.push_back(ksc_pkg::UNIT_LT);
            repeat ($urandom_range(ksc_pkg::MAX_NAME_LEN + 1, ksc_pkg::MAX_NAME_LEN + 3))
              units.push_back(letter_unit(8'($urandom_range(8'h61, 8'h7A))));
            units.push_back(ksc_pkg::UNIT_GT);
          end
          2: begin
            units.push_back(ksc_pkg::UNIT_LT);
            units.push_back(letter_unit(8'h65));
            units.push_back(16'($urandom_range(16'h0080, 16'hFFFF)));
            units.push_back(ksc_pkg::UNIT_GT);
          end
          3: units.push_back(16'($urandom_range(ksc_pkg::LOW_FIRST, ksc_pkg::LOW_LAST)));
          4: begin
            units.push_back(16'($urandom_range(ksc_pkg::HIGH_FIRST, ksc_pkg::HIGH_LAST)));
            units.push_back(text_unit());
          end
          5: begin
            // unclosed name runs to the end of the string
            units.push_back(ksc_pkg::UNIT_LT);
            repeat ($urandom_range(0, 4))
              units.push_back(letter_unit(8'($urandom_range(8'h61, 8'h7A))));
            return;
          end
          default: begin
            units.push_back(ksc_pkg::UNIT_LT);
            if ($urandom_range(0, 1) == 1) units.push_back(16'h0000);
            units.push_back(ksc_pkg::UNIT_GT);
          end
        endcase
      end else begin
        case ($urandom_range(0, 6))
          0, 1: begin
            nm = key_names[$urandom_range(0, ksc_pkg::NAME_COUNT - 1)];
            units.push_back(ksc_pkg::UNIT_LT);
            for (int i = 0; i < nm.len(); i++) units.push_back(letter_unit(nm[i]));
            units.push_back(ksc_pkg::UNIT_GT);
          end
          2: begin
            units.push_back(ksc_pkg::UNIT_LT);
            units.push_back(ksc_pkg::UNIT_LT);
          end
          3: begin
            units.push_back(ksc_pkg::UNIT_CR);
            if ($urandom_range(0, 2) != 0) units.push_back(ksc_pkg::UNIT_LF);
          end
          4: begin
            units.push_back(16'($urandom_range(ksc_pkg::HIGH_FIRST, ksc_pkg::HIGH_LAST)));
            units.push_back(16'($urandom_range(ksc_pkg::LOW_FIRST, ksc_pkg::LOW_LAST)));
          end
          default: units.push_back(text_unit());
        endcase
      end
    end
  endtask

  // ---- sender: bursts with random gaps ----
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    ksc_pkg::result_t seen;
    verdict_src_t     v;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        if (scan_unit(item, seen)) begin
          v = row_verdicts.pop_front();
          verdicts_due.push_back(v.typed ? v.res : seen);
        end
      end
      if (!item_valid || item_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (unit_feed.size() > 0) begin
          item       <= unit_feed.pop_front();
          item_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver: rotating stall pattern, one long hold-off ----
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [15:0] stall_pat = '1;
  int          pat_age = 0;

  task automatic report_fault(string what, ksc_pkg::result_t want, ksc_pkg::result_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch (%s): expected valid_res=%0b error_offset=%0d, %s%0b %s%0d",
               what, want.valid_res, want.error_offset,
               "got valid_res=", got.valid_res, "error_offset=", got.error_offset);
  endtask

  always @(posedge clk) begin
    ksc_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (verdicts_due.size() == 0) begin
          report_fault("no result pending", '0, result);
        end else begin
          want = verdicts_due.pop_front();
          if (want.valid_res !== result.valid_res)
            report_fault("valid_res", want, result);
          else if (want.error_offset !== result.error_offset)
            report_fault("error_offset", want, result);
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          pat_age   = 48;
          stall_pat = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
        end else begin
          pat_age--;
        end
        result_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // ---- sequence ----
  initial begin
    logic [15:0]      units [$];
    ksc_pkg::result_t typed_res;
    logic [7:0]       c;
    int               sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      units.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        c = dir_rows[r].text[i];
        case (c)
          "#": units.push_back(ksc_pkg::HIGH_FIRST);
          "$": units.push_back(ksc_pkg::HIGH_LAST);
          "%": units.push_back(ksc_pkg::LOW_FIRST);
          "&": units.push_back(ksc_pkg::LOW_LAST);
          "~": units.push_back(16'hFFFF);
          "@": units.push_back(16'h0000);
          "|": units.push_back(16'h0080);
          "^": units.push_back(ksc_pkg::UNIT_CR);
          "_": units.push_back(ksc_pkg::UNIT_LF);
          default: units.push_back({8'h00, c});
        endcase
      end
      typed_res.valid_res    = dir_rows[r].ok;
      typed_res.error_offset = dir_rows[r].offset;
      queue_string(units, dir_rows[r].typed, typed_res);
    end
    while (unit_feed.size() != 0) @(negedge clk);

    hold_go = 1'b1;
    sent = 0;
    while (sent < 1100) begin
      make_random_string(units);
      sent += units.size();
      queue_string(units, 1'b0, '0);
    end

    while (unit_feed.size() != 0 || item_valid) @(negedge clk);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("PASS key_sequence_syntax_checker");
    else
      $display("FAIL key_sequence_syntax_checker");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL key_sequence_syntax_checker");
    $finish;
  end

endmodule
